// ===== hdl/first_fit_block_allocator_assert.svh =====
// Assertion macros for the first-fit block allocator.
// Included by ffba_dp, which checks its own logic; depends on nothing.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFBA_ASSERT(label, prop, msg)
`define FFBA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/ffba_pkg.sv =====
// Shared types and codes of the first-fit block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffba_pkg;

  localparam int OFS_W  = 15;
  localparam int SIZE_W = 16;
  localparam int ST_W   = 2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef struct packed {
    logic    init;
    logic    accept;
    logic    scan;
    logic    shift;
    logic    split;
    logic    merge;
    logic    flush;
    logic    emit;
    logic    set_res;
    status_t res_code;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic zero;
    logic hit;
    logic miss;
    logic split_need;
    logic shift_done;
    logic merge_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/first_fit_block_allocator.sv =====
// First-fit block allocator with coalescing: a table of blocks over a byte arena.
// Each request word is answered by one result word. After reset the INIT state
// writes the initial free block before the first request is taken. An allocate
// walks the table one block per cycle up to the first fit. A split then moves
// the later blocks down one place at one block per cycle. A free walks to the
// block and then compacts the whole table. After the result word is emitted the
// controller returns to idle before the next request word is taken. The walk
// rates are set by the single read port of the block table memory.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
module first_fit_block_allocator #(
  parameter int ARENA_BYTES  = 32768,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // alloc_size[15:0], free_offset[30:16], zero pad
  input  logic [0:0]  s_tuser,  // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // payload_offset[14:0], zero pad
  output logic [1:0]  m_tuser   // status[1:0]
);

  ffba_pkg::cmd_t               cmd;
  ffba_pkg::stat_t              stat;
  logic [ffba_pkg::OFS_W-1:0]   ofs;
  ffba_pkg::status_t            st;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffba_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type_in    (s_tuser[0]),
    .alloc_size_in  (s_tdata[15:0]),
    .free_offset_in (s_tdata[30:16]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .payload_offset (ofs),
    .status         (st)
  );

  assign m_tdata = {1'b0, ofs};
  assign m_tuser = st;

endmodule

// ===== hdl/ffba_ctrl.sv =====
// Controller state machine of the first-fit block allocator.
// Sequences scan, shift, split and merge passes; depends on ffba_pkg.
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffba_pkg::stat_t stat,
  output ffba_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_SPLIT = 8'b0001_0000,
    S_MERGE = 8'b0010_0000,
    S_FLUSH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.res_code = ffba_pkg::ST_OK;
    state_next   = state;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ffba_pkg::ST_ZERO;
          state_next   = S_DONE;
        end else if (stat.hit) begin
          if (!stat.is_alloc) begin
            state_next = S_MERGE;
          end else if (stat.split_need) begin
            state_next = S_SHIFT;
          end else begin
            cmd.set_res = 1'b1;
            state_next  = S_DONE;
          end
        end else if (stat.miss) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = stat.is_alloc ? ffba_pkg::ST_NOFIT : ffba_pkg::ST_BADFREE;
          state_next   = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) state_next = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.split   = 1'b1;
        cmd.set_res = 1'b1;
        state_next  = S_DONE;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (stat.merge_done) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush   = 1'b1;
        cmd.set_res = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ===== hdl/ffba_dp.sv =====
// Datapath of the first-fit block allocator: block table memory, walk pointers,
// size arithmetic and the result register. Depends on ffba_pkg and the assert header.
`include "first_fit_block_allocator_assert.svh"
module ffba_dp #(
  parameter int ARENA_BYTES  = 32768,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffba_pkg::cmd_t                cmd,
  output ffba_pkg::stat_t               stat,
  input  logic                          req_type_in,
  input  logic [ffba_pkg::SIZE_W-1:0]   alloc_size_in,
  input  logic [ffba_pkg::OFS_W-1:0]    free_offset_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffba_pkg::OFS_W-1:0]    payload_offset,
  output ffba_pkg::status_t             status
);

  localparam int AW   = $clog2(ARENA_BYTES + 1);
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int CW   = ((AW > ffba_pkg::SIZE_W) ? AW : ffba_pkg::SIZE_W) + 2;
  localparam int EW   = ((AW > ffba_pkg::OFS_W) ? AW : ffba_pkg::OFS_W) + 1;
  localparam logic [CW-1:0]   HDR_C     = CW'(HEADER_BYTES);
  localparam logic [EW-1:0]   HDR_E     = EW'(HEADER_BYTES);
  localparam logic [AW-1:0]   HDR_A     = AW'(HEADER_BYTES);
  localparam logic [AW-1:0]   INIT_SIZE = AW'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [CNTW-1:0] MAXC      = CNTW'(MAX_BLOCKS);

  logic [AW-1:0] mem_start [MAX_BLOCKS];
  logic [AW-1:0] mem_size  [MAX_BLOCKS];
  logic          mem_free  [MAX_BLOCKS];
  logic [AW-1:0] rd_start, rd_size;
  logic          rd_free;

  logic                        req_type;
  logic [ffba_pkg::SIZE_W-1:0] req_size;
  logic [ffba_pkg::OFS_W-1:0]  req_ofs;
  logic [CNTW-1:0]             count, ra, rdi, hit_idx, wa;
  logic                        rv, cur_valid, cur_free;
  logic [AW-1:0]               hit_start, hit_size, cur_start, cur_size;
  ffba_pkg::status_t           res_st;

  logic [CNTW-1:0] ra_m1, hit_p1;
  logic            can_read, eff_free, join_cur, fit;
  logic            wr_en, wr_free;
  logic [IW-1:0]   wr_addr, rd_addr;
  logic [AW-1:0]   wr_start, wr_size;
  logic [CW-1:0]   need_c, split_start_c, split_size_c;
  logic [EW-1:0]   pay_e;

  assign ra_m1  = ra - 1'b1;
  assign hit_p1 = hit_idx + 1'b1;
  assign need_c = CW'(req_size) + HDR_C;

  always_comb begin
    if (cmd.shift) begin
      can_read = (ra > hit_p1);
      rd_addr  = ra_m1[IW-1:0];
    end else begin
      can_read = (ra < count);
      rd_addr  = ra[IW-1:0];
    end
  end

  assign eff_free = rd_free | (rdi == hit_idx);
  assign join_cur = cur_valid && cur_free && eff_free;

  assign stat.is_alloc   = (req_type == ffba_pkg::REQ_ALLOC);
  assign stat.zero       = stat.is_alloc && (req_size == '0);
  assign fit = stat.is_alloc ? (rd_free && (CW'(rd_size) >= CW'(req_size)))
                             : (!rd_free && ((EW'(rd_start) + HDR_E) == EW'(req_ofs)));
  assign stat.hit        = rv && !stat.zero && fit;
  assign stat.miss       = !rv && (ra >= count);
  assign stat.split_need = (CW'(rd_size) > need_c) && (count < MAXC);
  assign stat.shift_done = !rv && !(ra > hit_p1);
  assign stat.merge_done = !rv && (ra >= count);
  assign stat.out_free   = !out_valid || out_ready;

  assign split_start_c = CW'(hit_start) + need_c;
  assign split_size_c  = CW'(hit_size) - need_c;
  assign pay_e         = EW'(hit_start) + HDR_E;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_start = cur_start;
    wr_size  = cur_size;
    wr_free  = cur_free;
    priority if (cmd.init) begin
      wr_en    = 1'b1;
      wr_start = '0;
      wr_size  = INIT_SIZE;
      wr_free  = 1'b1;
    end else if (cmd.scan && stat.hit && stat.is_alloc) begin
      wr_en    = 1'b1;
      wr_addr  = rdi[IW-1:0];
      wr_start = rd_start;
      wr_size  = stat.split_need ? AW'(req_size) : rd_size;
      wr_free  = 1'b0;
    end else if (cmd.shift && rv) begin
      wr_en    = 1'b1;
      wr_addr  = IW'(rdi + 1'b1);
      wr_start = rd_start;
      wr_size  = rd_size;
      wr_free  = rd_free;
    end else if (cmd.split) begin
      wr_en    = 1'b1;
      wr_addr  = hit_p1[IW-1:0];
      wr_start = split_start_c[AW-1:0];
      wr_size  = split_size_c[AW-1:0];
      wr_free  = 1'b1;
    end else if ((cmd.merge && rv && cur_valid && !join_cur) || cmd.flush) begin
      wr_en   = 1'b1;
      wr_addr = wa[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_size[wr_addr]  <= wr_size;
      mem_free[wr_addr]  <= wr_free;
    end
    rd_start <= mem_start[rd_addr];
    rd_size  <= mem_size[rd_addr];
    rd_free  <= mem_free[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type <= req_type_in;
      req_size <= alloc_size_in;
      req_ofs  <= free_offset_in;
    end
    if (cmd.scan) begin
      if (stat.hit) begin
        hit_idx   <= rdi;
        hit_start <= rd_start;
        hit_size  <= rd_size;
        wa        <= '0;
      end else begin
        rdi <= ra;
      end
    end
    if (cmd.shift) rdi <= ra_m1;
    if (cmd.merge) begin
      rdi <= ra;
      if (rv) begin
        if (join_cur) begin
          cur_size <= cur_size + HDR_A + rd_size;
        end else begin
          cur_start <= rd_start;
          cur_size  <= rd_size;
          cur_free  <= eff_free;
          if (cur_valid) wa <= wa + 1'b1;
        end
      end
    end
    if (cmd.set_res) res_st <= cmd.res_code;
    if (cmd.emit) begin
      status <= res_st;
      payload_offset <= (res_st == ffba_pkg::ST_OK && stat.is_alloc) ?
                        pay_e[ffba_pkg::OFS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= CNTW'(1);
      ra        <= '0;
      rv        <= 1'b0;
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init) count <= CNTW'(1);
      if (cmd.accept) begin
        ra <= '0;
        rv <= 1'b0;
      end
      if (cmd.scan) begin
        if (stat.hit) begin
          ra        <= stat.is_alloc ? count : '0;
          rv        <= 1'b0;
          cur_valid <= 1'b0;
        end else begin
          rv <= can_read;
          if (can_read) ra <= ra + 1'b1;
        end
      end
      if (cmd.shift) begin
        rv <= can_read;
        if (can_read) ra <= ra_m1;
      end
      if (cmd.merge) begin
        rv <= can_read;
        if (can_read) ra <= ra + 1'b1;
        if (rv) cur_valid <= 1'b1;
      end
      if (cmd.split) count <= count + 1'b1;
      if (cmd.flush) count <= wa + 1'b1;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FFBA_ASSERT(a_count_range, (count != '0) && (count <= MAXC), "block count out of range")
  `FFBA_ASSERT_NEXT(a_split_grows, cmd.split, count == $past(count) + 1'b1, "split lost a block")
  `FFBA_ASSERT(a_merge_order, !(cmd.merge && wr_en) || (wa < ra), "merge write passed read")

endmodule

// ===== tb/tb_first_fit_block_allocator.sv =====
// Self-checking testbench for first_fit_block_allocator: drives allocate and free
// words, predicts every result with a block-table model, and checks the result words.
// Depends on ffba_pkg and the first_fit_block_allocator RTL.
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARENA   = 32768;
  localparam int HDR     = 24;
  localparam int NBLK    = 1024;
  localparam int LIMIT   = 8000000;
  localparam int DRAIN   = 2200;

  typedef logic [ffba_pkg::SIZE_W-1:0] size_word_t;
  typedef logic [ffba_pkg::OFS_W-1:0]  ofs_word_t;

  typedef struct {
    ofs_word_t         ofs;
    ffba_pkg::status_t st;
  } alloc_result_t;

  class heap_scoreboard;
    int unsigned   hdr_at[NBLK];
    int unsigned   payload[NBLK];
    bit            is_free[NBLK];
    int unsigned   nblocks;
    alloc_result_t pending_results[$];
    int unsigned   live_offsets[$];
    int unsigned   last_freed;
    int            errors;

    function new();
      nblocks = 1;
      hdr_at[0] = 0;
      payload[0] = ARENA - HDR;
      is_free[0] = 1'b1;
      errors = 0;
      last_freed = HDR;
    endfunction

    function void coalesce();
      int unsigned w;
      w = 0;
      for (int r = 0; r < nblocks; r++) begin
        if (w > 0 && is_free[w-1] && is_free[r]) begin
          payload[w-1] += HDR + payload[r];
        end else begin
          hdr_at[w] = hdr_at[r];
          payload[w] = payload[r];
          is_free[w] = is_free[r];
          w++;
        end
      end
      nblocks = w;
    endfunction

    function void note_request(logic req, size_word_t size, ofs_word_t ofs);
      alloc_result_t res;
      int idx;
      res.ofs = '0;
      res.st = ffba_pkg::ST_OK;
      idx = -1;
      if (req == ffba_pkg::REQ_ALLOC) begin
        if (size == 0) begin
          res.st = ffba_pkg::ST_ZERO;
        end else begin
          for (int i = 0; i < nblocks; i++)
            if (idx < 0 && is_free[i] && payload[i] >= size) idx = i;
          if (idx < 0) begin
            res.st = ffba_pkg::ST_NOFIT;
          end else begin
            if (payload[idx] > size + HDR && nblocks < NBLK) begin
              for (int k = nblocks; k > idx + 1; k--) begin
                hdr_at[k] = hdr_at[k-1];
                payload[k] = payload[k-1];
                is_free[k] = is_free[k-1];
              end
              hdr_at[idx+1] = hdr_at[idx] + HDR + size;
              payload[idx+1] = payload[idx] - size - HDR;
              is_free[idx+1] = 1'b1;
              payload[idx] = 32'(size);
              nblocks++;
            end
            is_free[idx] = 1'b0;
            res.ofs = ofs_word_t'(hdr_at[idx] + HDR);
            live_offsets.push_back(hdr_at[idx] + HDR);
          end
        end
      end else begin
        for (int i = 0; i < nblocks; i++)
          if (idx < 0 && !is_free[i] && hdr_at[i] + HDR == ofs) idx = i;
        if (idx < 0) begin
          res.st = ffba_pkg::ST_BADFREE;
        end else begin
          is_free[idx] = 1'b1;
          coalesce();
          last_freed = 32'(ofs);
          foreach (live_offsets[j])
            if (live_offsets[j] == ofs) begin
              live_offsets.delete(j);
              break;
            end
        end
      end
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("error at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [15:0] data, logic [1:0] user);
      alloc_result_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word ofs=%0d st=%0d", data[14:0], user));
      end else begin
        exp = pending_results.pop_front();
        if (data[14:0] !== exp.ofs)
          report_mismatch($sformatf("payload_offset %0d, expected %0d", data[14:0], exp.ofs));
        if (user !== exp.st)
          report_mismatch($sformatf("status %0d, expected %0d", user, exp.st));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  heap_scoreboard sb;
  int             idle_pct;
  int             stall_pct;
  int             hold_req;
  int             hold_left;
  longint         cycles;

  first_fit_block_allocator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(logic req, size_word_t size, ofs_word_t ofs);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {1'b0, ofs, size};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, size, ofs);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic random_words(int n);
    int r;
    int live_n;
    size_word_t size;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      live_n = sb.live_offsets.size();
      if (r < ((live_n > 30) ? 65 : 40)) begin
        r = $urandom_range(99);
        if (live_n > 0 && r < 75)
          send_word(ffba_pkg::REQ_FREE, size_word_t'($urandom),
                    ofs_word_t'(sb.live_offsets[$urandom_range(live_n - 1)]));
        else if (r < 88)
          send_word(ffba_pkg::REQ_FREE, size_word_t'($urandom),
                    ofs_word_t'($urandom_range(32767)));
        else
          send_word(ffba_pkg::REQ_FREE, size_word_t'($urandom), ofs_word_t'(sb.last_freed));
      end else begin
        r = $urandom_range(99);
        if (r < 4) size = '0;
        else if (r < 9) size = size_word_t'($urandom_range(65535));
        else if (r < 12) size = size_word_t'(ARENA - HDR);
        else if (r < 20) size = size_word_t'($urandom_range(1, 2000));
        else size = size_word_t'($urandom_range(1, 300));
        send_word(ffba_pkg::REQ_ALLOC, size, ofs_word_t'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero size, no fit, splits, merges, bad frees, exact and whole fits.
    send_word(ffba_pkg::REQ_ALLOC, 16'd0, 15'd0);
    send_word(ffba_pkg::REQ_ALLOC, 16'hFFFF, 15'h7FFF);
    send_word(ffba_pkg::REQ_ALLOC, size_word_t'(ARENA - HDR + 1), 15'd0);
    send_word(ffba_pkg::REQ_ALLOC, 16'd100, 15'd0);
    send_word(ffba_pkg::REQ_ALLOC, 16'd200, 15'd0);
    send_word(ffba_pkg::REQ_ALLOC, 16'd300, 15'd0);
    send_word(ffba_pkg::REQ_FREE, 16'd0, ofs_word_t'(HDR + 100 + HDR));
    send_word(ffba_pkg::REQ_FREE, 16'd0, ofs_word_t'(HDR));
    send_word(ffba_pkg::REQ_FREE, 16'd0, ofs_word_t'(HDR));
    send_word(ffba_pkg::REQ_FREE, 16'd0, 15'd5);
    send_word(ffba_pkg::REQ_FREE, 16'd0, 15'h7FFF);
    send_word(ffba_pkg::REQ_ALLOC, 16'd300, 15'd0);
    send_word(ffba_pkg::REQ_ALLOC, 16'd1, 15'd0);
    send_word(ffba_pkg::REQ_FREE, 16'd0, ofs_word_t'(HDR));
    send_word(ffba_pkg::REQ_ALLOC, 16'd276, 15'd0);
    send_word(ffba_pkg::REQ_FREE, 16'd0, ofs_word_t'(HDR));
    send_word(ffba_pkg::REQ_ALLOC, 16'd275, 15'd0);
    while (sb.live_offsets.size() > 0)
      send_word(ffba_pkg::REQ_FREE, 16'd0, ofs_word_t'(sb.live_offsets[0]));
    send_word(ffba_pkg::REQ_ALLOC, size_word_t'(ARENA - HDR), 15'd0);
    send_word(ffba_pkg::REQ_ALLOC, 16'd1, 15'd0);
    send_word(ffba_pkg::REQ_FREE, 16'hFFFF, ofs_word_t'(HDR));
    drain_results();

    random_words(120);
    idle_pct = 69;
    random_words(110);
    drain_results();
    idle_pct = 0;
    stall_pct = 69;
    random_words(110);
    stall_pct = 0;
    hold_req = 3000;
    random_words(20);
    drain_results();
    idle_pct = 25;
    stall_pct = 25;
    random_words(110);
    idle_pct = 0;
    stall_pct = 0;
    random_words(90);
    drain_results();

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
